// ===== rtl/hcbd_pkg.sv =====
package hcbd_pkg;

	// Line-end characters of the chunked framing.
	localparam logic [7:0] ASCII_CR = 8'h0D;
	localparam logic [7:0] ASCII_LF = 8'h0A;

	// Status codes carried in the result.
	localparam logic [1:0] ST_BUSY  = 2'd0;
	localparam logic [1:0] ST_DONE  = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;
	localparam logic [1:0] ST_RSVD  = 2'd3;

	// Decoder phases.
	localparam logic [2:0] PH_SIZE    = 3'd0;
	localparam logic [2:0] PH_SIZE_LF = 3'd1;
	localparam logic [2:0] PH_DATA    = 3'd2;
	localparam logic [2:0] PH_DATA_CR = 3'd3;
	localparam logic [2:0] PH_DATA_LF = 3'd4;
	localparam logic [2:0] PH_DONE    = 3'd5;
	localparam logic [2:0] PH_ERROR   = 3'd6;

	localparam logic [23:0] MAX_CHUNK_RESET = 24'hFFFFFF;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t r;
		r.ok    = 1'b1;
		r.value = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			r.value = 4'(c - 8'h30);
		end else if (c inside {[8'h61:8'h66]}) begin
			r.value = 4'(c - 8'h57);
		end else if (c inside {[8'h41:8'h46]}) begin
			r.value = 4'(c - 8'h37);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== rtl/http_chunked_body_decoder.sv =====
// Decodes an HTTP/1.1 chunked body one byte per transaction. Each accepted byte
// yields exactly one result transaction, in the cycle after acceptance, through a
// single output register; a new byte is taken every cycle while that register is
// empty or being drained, so sustained throughput is one byte per clock. A
// payload byte is flagged in tuser bit 0; status (in progress, done, error) is
// in tuser bits 2:1. Done and error are sticky until a byte arrives with the
// restart flag set, which clears the decoder before that byte is decoded.
// cfg_we/cfg_wdata set the largest accepted chunk size (masked to SIZE_BITS);
// write it only while the block is idle.
module http_chunked_body_decoder #(
	parameter int SIZE_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata,   // max_chunk_size
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // [7:0] byte_in
	input  logic        s_tuser,     // [0] restart
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,     // [7:0] data_byte
	output logic [2:0]  m_tuser      // [0] data_valid, [2:1] status
);

	logic [23:0]          max_chunk_q;
	logic [2:0]           phase_q;
	logic [SIZE_BITS-1:0] rem_q;
	logic                 digit_seen_q;

	logic [2:0]           phase_d;
	logic [SIZE_BITS-1:0] rem_d;
	logic                 digit_seen_d;

	logic [2:0]           phase_cur;
	logic [SIZE_BITS-1:0] rem_cur;
	logic                 digit_seen_cur;

	logic [SIZE_BITS+23:0] limit_ext;
	logic [SIZE_BITS-1:0]  limit;
	logic [SIZE_BITS+3:0]  next_size;
	hcbd_pkg::hex_digit_t  hex;

	logic       res_valid;
	logic [7:0] res_byte;
	logic [1:0] res_status;
	logic       accept;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = !m_tvalid || m_tready;

	assign limit_ext = {{SIZE_BITS{1'b0}}, max_chunk_q};
	assign limit     = limit_ext[SIZE_BITS-1:0];

	// Restart clears the decoder ahead of the byte that carries it.
	assign phase_cur      = s_tuser ? hcbd_pkg::PH_SIZE : phase_q;
	assign rem_cur        = s_tuser ? '0 : rem_q;
	assign digit_seen_cur = s_tuser ? 1'b0 : digit_seen_q;

	assign hex       = hcbd_pkg::hex_decode(s_tdata);
	assign next_size = {rem_cur, 4'd0} + {{SIZE_BITS{1'b0}}, hex.value};

	always_comb begin
		phase_d      = phase_cur;
		rem_d        = rem_cur;
		digit_seen_d = digit_seen_cur;
		res_valid    = 1'b0;
		res_byte     = 8'd0;
		case (phase_cur)
			hcbd_pkg::PH_SIZE: begin
				if (hex.ok) begin
					if (next_size > {4'd0, limit}) begin
						phase_d = hcbd_pkg::PH_ERROR;
					end else begin
						rem_d        = next_size[SIZE_BITS-1:0];
						digit_seen_d = 1'b1;
					end
				end else if (s_tdata == hcbd_pkg::ASCII_CR && digit_seen_cur) begin
					phase_d = hcbd_pkg::PH_SIZE_LF;
				end else begin
					phase_d = hcbd_pkg::PH_ERROR;
				end
			end
			hcbd_pkg::PH_SIZE_LF: begin
				if (s_tdata != hcbd_pkg::ASCII_LF) begin
					phase_d = hcbd_pkg::PH_ERROR;
				end else if (rem_cur == '0) begin
					phase_d = hcbd_pkg::PH_DONE;
				end else begin
					phase_d = hcbd_pkg::PH_DATA;
				end
			end
			hcbd_pkg::PH_DATA: begin
				res_valid = 1'b1;
				res_byte  = s_tdata;
				rem_d     = rem_cur - SIZE_BITS'(1);
				if (rem_cur == SIZE_BITS'(1)) begin
					phase_d = hcbd_pkg::PH_DATA_CR;
				end
			end
			hcbd_pkg::PH_DATA_CR: begin
				phase_d = (s_tdata == hcbd_pkg::ASCII_CR) ? hcbd_pkg::PH_DATA_LF
				                                          : hcbd_pkg::PH_ERROR;
			end
			hcbd_pkg::PH_DATA_LF: begin
				if (s_tdata == hcbd_pkg::ASCII_LF) begin
					phase_d      = hcbd_pkg::PH_SIZE;
					rem_d        = '0;
					digit_seen_d = 1'b0;
				end else begin
					phase_d = hcbd_pkg::PH_ERROR;
				end
			end
			hcbd_pkg::PH_DONE: begin
				phase_d = hcbd_pkg::PH_DONE;
			end
			default: begin
				phase_d = hcbd_pkg::PH_ERROR;
			end
		endcase

		if (phase_d == hcbd_pkg::PH_DONE) begin
			res_status = hcbd_pkg::ST_DONE;
		end else if (phase_d == hcbd_pkg::PH_ERROR) begin
			res_status = hcbd_pkg::ST_ERROR;
		end else begin
			res_status = hcbd_pkg::ST_BUSY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chunk_q <= hcbd_pkg::MAX_CHUNK_RESET;
		end else if (cfg_we) begin
			max_chunk_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= hcbd_pkg::PH_SIZE;
			rem_q        <= '0;
			digit_seen_q <= 1'b0;
		end else if (accept) begin
			phase_q      <= phase_d;
			rem_q        <= rem_d;
			digit_seen_q <= digit_seen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (accept) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata <= res_byte;
			m_tuser <= {res_status, res_valid};
		end
	end

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[2:1] != hcbd_pkg::ST_RSVD)
		else $error("reserved status code on output");

	a_payload_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[2:1] == hcbd_pkg::ST_BUSY)
		else $error("payload byte reported with final status");

	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == hcbd_pkg::PH_DATA |-> rem_q != '0)
		else $error("data phase with no bytes remaining");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !s_tuser && phase_q == hcbd_pkg::PH_DONE
		|=> phase_q == hcbd_pkg::PH_DONE && m_tuser[2:1] == hcbd_pkg::ST_DONE)
		else $error("done status left without restart");

endmodule
